/* sv/mcpu_pkg.sv */
// shared types and constants for the microcoded 8-bit cpu step block
// no dependencies; used by every module under sv/

package mcpu_pkg;

   localparam int MEM_DEPTH_DEF = 16;   // default byte memory depth
   localparam int MEM_ADDR_MAX_W = 8;   // widest byte memory index (256 entries)
   localparam int CS_ADDR_W = 10;       // control store index width
   localparam int CS_DATA_W = 16;       // control word width
   localparam int WRAP_STEPS = 6;       // 10-bit address over depth >= 16 leaves a 6-bit quotient
   localparam logic [2:0] STEP_LAST = 3'd4;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_CS_WR  = 2'd1,
      ACT_MEM_WR = 2'd2,
      ACT_NOP    = 2'd3
   } act_type;

   // control word, msb first
   typedef struct packed {
      logic hlt;
      logic mi;
      logic ri;
      logic ro;
      logic io;
      logic ii;
      logic ai;
      logic ao;
      logic eo;
      logic su;
      logic bi;
      logic oi;
      logic ce;
      logic co;
      logic j;
      logic fi;
   } cw_type;

   typedef struct packed {
      logic                   en;
      logic [CS_ADDR_W-1:0]   addr;
      logic [CS_DATA_W-1:0]   data;
   } cs_wr_type;

   typedef struct packed {
      logic                      en;
      logic [MEM_ADDR_MAX_W-1:0] addr;
      logic [7:0]                data;
   } ram_wr_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_value;
      logic       halted;
      logic [7:0] pc_now;
   } rsp_type;

   // address mod depth by restoring subtraction, depth known at elaboration
   function automatic logic [15:0] wrap_index(logic [15:0] addr, int depth);
      logic [15:0] rem;
      logic [15:0] sub_val;
      rem = addr;
      for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
         sub_val = 16'(depth << k);
         if (rem >= sub_val) begin
            rem = rem - sub_val;
         end
      end
      return rem;
   endfunction

endpackage

/* sv/mcpu_cstore.sv */
// control store: 1024 x 16 synchronous memory, one write and one read port
// uses mcpu_pkg for widths and the write port struct

module mcpu_cstore (
   input  logic                                 clock,
   input  mcpu_pkg::cs_wr_type                  wr,
   input  logic                                 rd_en,
   input  logic [mcpu_pkg::CS_ADDR_W-1:0]       rd_addr,
   output logic [mcpu_pkg::CS_DATA_W-1:0]       rd_data
);

   localparam int DEPTH = 1 << mcpu_pkg::CS_ADDR_W;

   logic [mcpu_pkg::CS_DATA_W-1:0] mem [DEPTH];
   logic [mcpu_pkg::CS_DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/mcpu_ram.sv */
// byte memory of MEM_DEPTH entries, synchronous read with a registered output
// uses mcpu_pkg for the write port struct

module mcpu_ram #(
   parameter int MEM_DEPTH = mcpu_pkg::MEM_DEPTH_DEF
) (
   input  logic                                    clock,
   input  mcpu_pkg::ram_wr_type                    wr,
   input  logic                                    rd_en,
   input  logic [mcpu_pkg::MEM_ADDR_MAX_W-1:0]     rd_addr,
   output logic [7:0]                              rd_data
);

   localparam int ADDR_W = $clog2(MEM_DEPTH);

   logic [7:0] mem [MEM_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[ADDR_W-1:0]] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr[ADDR_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/mcpu_core.sv */
// architectural registers, bus, alu and sinks of the microcoded cpu
// uses mcpu_pkg; drives the read and write ports of mcpu_cstore and mcpu_ram

module mcpu_core #(
   parameter int MEM_DEPTH = mcpu_pkg::MEM_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 exec,
   input  mcpu_pkg::act_type                    act,
   input  logic [9:0]                           load_address,
   input  logic [15:0]                          load_data,
   input  logic [mcpu_pkg::CS_DATA_W-1:0]       cs_rd_data,
   input  logic [7:0]                           ram_rd_data,
   output logic [mcpu_pkg::CS_ADDR_W-1:0]       cs_rd_addr,
   output logic [mcpu_pkg::MEM_ADDR_MAX_W-1:0]  ram_rd_addr,
   output mcpu_pkg::cs_wr_type                  cs_wr,
   output mcpu_pkg::ram_wr_type                 ram_wr,
   output mcpu_pkg::rsp_type                    rsp
);

   logic [7:0] a_ff, a_in;
   logic [7:0] b_ff, b_in;
   logic [7:0] mar_ff, mar_in;
   logic [2:0] step_ff, step_in;
   logic [7:0] ir_ff, ir_in;
   logic [7:0] pc_ff, pc_in;
   logic       carry_ff, carry_in;
   logic       zero_ff, zero_in;
   logic       halt_ff, halt_in;

   mcpu_pkg::cw_type cw;
   logic        run;
   logic [7:0]  pc_inc;
   logic [7:0]  b_op;
   logic [8:0]  sum;
   logic [7:0]  bus;
   logic [15:0] mar_wrap;
   logic [15:0] ld_wrap;

   assign cw = mcpu_pkg::cw_type'(cs_rd_data);
   assign run = exec && (act == mcpu_pkg::ACT_TICK) && !halt_ff;

   // next micro step address from the current state, bit 7 always clear
   assign cs_rd_addr = {zero_ff, carry_ff, 1'b0, ir_ff[7:4], step_ff};

   assign mar_wrap = mcpu_pkg::wrap_index({8'd0, mar_ff}, MEM_DEPTH);
   assign ld_wrap  = mcpu_pkg::wrap_index({6'd0, load_address}, MEM_DEPTH);
   assign ram_rd_addr = mar_wrap[mcpu_pkg::MEM_ADDR_MAX_W-1:0];

   assign pc_inc = cw.ce ? 8'(pc_ff + 8'd1) : pc_ff;
   assign b_op   = cw.su ? 8'(~b_ff + 8'd1) : b_ff;
   assign sum    = {1'b0, a_ff} + {1'b0, b_op};

   always_comb begin
      priority if (cw.co) begin
         bus = pc_inc;
      end else if (cw.eo) begin
         bus = sum[7:0];
      end else if (cw.ao) begin
         bus = a_ff;
      end else if (cw.io) begin
         bus = {4'd0, ir_ff[3:0]};
      end else if (cw.ro) begin
         bus = ram_rd_data;
      end else begin
         bus = 8'd0;
      end
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      mar_in   = mar_ff;
      step_in  = step_ff;
      ir_in    = ir_ff;
      pc_in    = pc_ff;
      carry_in = carry_ff;
      zero_in  = zero_ff;
      halt_in  = halt_ff;
      if (run) begin
         pc_in = cw.j ? bus : pc_inc;
         if (cw.hlt) begin
            halt_in = 1'b1;
         end
         // flags only follow the alu when it drives the bus
         if (!cw.co && cw.eo && cw.fi) begin
            zero_in  = (sum[7:0] == 8'd0);
            carry_in = sum[8];
         end
         if (cw.bi) begin
            b_in = bus;
         end
         if (cw.ai) begin
            a_in = bus;
         end
         if (cw.ii) begin
            ir_in = bus;
         end
         if (cw.mi) begin
            mar_in = bus;
         end
         step_in = (step_ff >= mcpu_pkg::STEP_LAST) ? 3'd0 : 3'(step_ff + 3'd1);
      end
   end

   always_comb begin
      cs_wr.en   = exec && (act == mcpu_pkg::ACT_CS_WR);
      cs_wr.addr = load_address;
      cs_wr.data = load_data;

      // ram in uses the address register from before this step
      if (act == mcpu_pkg::ACT_MEM_WR) begin
         ram_wr.en   = exec;
         ram_wr.addr = ld_wrap[mcpu_pkg::MEM_ADDR_MAX_W-1:0];
         ram_wr.data = load_data[7:0];
      end else begin
         ram_wr.en   = run && cw.ri;
         ram_wr.addr = mar_wrap[mcpu_pkg::MEM_ADDR_MAX_W-1:0];
         ram_wr.data = bus;
      end

      rsp.out_valid = run && cw.oi;
      rsp.out_value = (run && cw.oi) ? bus : 8'd0;
      rsp.halted    = halt_in;
      rsp.pc_now    = pc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff     <= 8'd0;
         b_ff     <= 8'd0;
         mar_ff   <= 8'd0;
         step_ff  <= 3'd0;
         ir_ff    <= 8'd0;
         pc_ff    <= 8'd0;
         carry_ff <= 1'b0;
         zero_ff  <= 1'b0;
         halt_ff  <= 1'b0;
      end else if (exec) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         mar_ff   <= mar_in;
         step_ff  <= step_in;
         ir_ff    <= ir_in;
         pc_ff    <= pc_in;
         carry_ff <= carry_in;
         zero_ff  <= zero_in;
         halt_ff  <= halt_in;
      end
   end

   // a halted machine keeps its state
   a_halt_frozen: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff && $stable(pc_ff) && $stable(a_ff) && $stable(step_ff))
      else $error("state changed after halt");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= mcpu_pkg::STEP_LAST)
      else $error("micro step out of range");

   a_step_moves: assert property (@(posedge clock) disable iff (reset)
      run |=> step_ff != $past(step_ff))
      else $error("micro step did not advance on a tick");

   a_out_on_tick: assert property (@(posedge clock) disable iff (reset)
      rsp.out_valid |-> exec && (act == mcpu_pkg::ACT_TICK) && !halt_ff && cw.oi)
      else $error("output latched outside a running tick");

endmodule

/* sv/microcoded_8bit_cpu_step.sv */
// top level of the microcoded 8-bit cpu step block
// uses mcpu_pkg, mcpu_cstore, mcpu_ram and mcpu_core
//
// usage:
//   req channel: one request per item. tuser carries the action (tick, control
//   store write, memory write, no-op); tdata carries load address and data.
//   rsp channel: exactly one response per request, in order. tuser flags an
//   output latch, tdata carries the output byte, halt state and program counter.
//   a request is taken into the execute slot; in that cycle the control store
//   and the byte memory are read from the current state and the read data is
//   registered. once the output register is free, the control word is applied,
//   the state is written back and the response is loaded into that register.
//   a new request is not taken while one waits in the execute slot, since the
//   synchronous control store read must see the state the previous tick left.
//   reset clears all cpu registers and both handshakes; the control store and
//   byte memory are not cleared and must be loaded before use.
//   if rsp_tready stays low, one response waits in the output register while
//   the next request is still accepted and read; it then holds until the
//   output frees up and req_tready stays low meanwhile.

module microcoded_8bit_cpu_step #(
   parameter int MEM_DEPTH = mcpu_pkg::MEM_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [9:0] load_address, [25:10] load_data, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_value, [8] halted, [16:9] pc_now, rest zero
   output logic [0:0]  rsp_tuser    // [0] out_valid
);

   logic                  s1_valid_ff, s1_valid_in;
   mcpu_pkg::act_type     act_ff;
   logic [9:0]            addr_ff;
   logic [15:0]           data_ff;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   mcpu_pkg::rsp_type     rsp_ff;

   logic                  accept;
   logic                  exec;
   mcpu_pkg::rsp_type     rsp_next;
   mcpu_pkg::cs_wr_type   cs_wr;
   mcpu_pkg::ram_wr_type  ram_wr;
   logic [mcpu_pkg::CS_ADDR_W-1:0]      cs_rd_addr;
   logic [mcpu_pkg::CS_DATA_W-1:0]      cs_rd_data;
   logic [mcpu_pkg::MEM_ADDR_MAX_W-1:0] ram_rd_addr;
   logic [7:0]                          ram_rd_data;

   // the execute slot must drain before the next read sees fresh state
   assign req_tready = !s1_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign exec       = s1_valid_ff && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (exec) begin
         s1_valid_in = 1'b0;
      end
      rsp_tvalid_in = rsp_tvalid_ff;
      if (exec) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= mcpu_pkg::act_type'(req_tuser[1:0]);
         addr_ff <= req_tdata[9:0];
         data_ff <= req_tdata[25:10];
      end
      if (exec) begin
         rsp_ff <= rsp_next;
      end
   end

   mcpu_cstore u_cstore (
      .clock   (clock),
      .wr      (cs_wr),
      .rd_en   (accept),
      .rd_addr (cs_rd_addr),
      .rd_data (cs_rd_data)
   );

   mcpu_ram #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_en   (accept),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mcpu_core #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .exec         (exec),
      .act          (act_ff),
      .load_address (addr_ff),
      .load_data    (data_ff),
      .cs_rd_data   (cs_rd_data),
      .ram_rd_data  (ram_rd_data),
      .cs_rd_addr   (cs_rd_addr),
      .ram_rd_addr  (ram_rd_addr),
      .cs_wr        (cs_wr),
      .ram_wr       (ram_wr),
      .rsp          (rsp_next)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.pc_now, rsp_ff.halted, rsp_ff.out_value};
   assign rsp_tuser  = rsp_ff.out_valid;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for microcoded_8bit_cpu_step: sap-style and random microcode runs
// depends on mcpu_pkg and the block's rtl; a local model of the cpu state predicts each response

module tb;

   localparam int RAM_WORDS = mcpu_pkg::MEM_DEPTH_DEF;
   localparam int GEN = 0;              // state copy advanced while stimulus is built
   localparam int CHK = 1;              // state copy advanced on accepted requests
   localparam int TARGET_ITEMS = 1000;

   localparam logic [15:0] CW_FI  = 16'h0001;
   localparam logic [15:0] CW_J   = 16'h0002;
   localparam logic [15:0] CW_CO  = 16'h0004;
   localparam logic [15:0] CW_CE  = 16'h0008;
   localparam logic [15:0] CW_OI  = 16'h0010;
   localparam logic [15:0] CW_BI  = 16'h0020;
   localparam logic [15:0] CW_SU  = 16'h0040;
   localparam logic [15:0] CW_EO  = 16'h0080;
   localparam logic [15:0] CW_AO  = 16'h0100;
   localparam logic [15:0] CW_AI  = 16'h0200;
   localparam logic [15:0] CW_II  = 16'h0400;
   localparam logic [15:0] CW_IO  = 16'h0800;
   localparam logic [15:0] CW_RO  = 16'h1000;
   localparam logic [15:0] CW_RI  = 16'h2000;
   localparam logic [15:0] CW_MI  = 16'h4000;
   localparam logic [15:0] CW_HLT = 16'h8000;

   localparam logic [3:0] OP_NOP = 4'd0;
   localparam logic [3:0] OP_LDA = 4'd1;
   localparam logic [3:0] OP_ADD = 4'd2;
   localparam logic [3:0] OP_SUB = 4'd3;
   localparam logic [3:0] OP_STA = 4'd4;
   localparam logic [3:0] OP_LDI = 4'd5;
   localparam logic [3:0] OP_JMP = 4'd6;
   localparam logic [3:0] OP_JC  = 4'd7;
   localparam logic [3:0] OP_JZ  = 4'd8;
   localparam logic [3:0] OP_ADI = 4'd9;
   localparam logic [3:0] OP_OUT = 4'd14;
   localparam logic [3:0] OP_HLT = 4'd15;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] breg;
      logic [7:0] mar;
      logic [7:0] ir;
      logic [7:0] pc;
      logic [2:0] step;
      logic       carry;
      logic       zero;
      logic       halt;
   } cpu_regs_type;

   typedef struct packed {
      logic              hold;     // wait for every response before this request goes out
      mcpu_pkg::act_type act;
      logic [9:0]        laddr;
      logic [15:0]       ldata;
   } req_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   cpu_regs_type regs [2];
   logic [15:0]  cstore_img [2][1024];
   logic [7:0]   ram_img [2][RAM_WORDS];
   bit           cs_written [1024];

   req_item_type      pend_q [$];
   mcpu_pkg::rsp_type want_rsp_q [$];
   bit          hold_next = 1'b0;
   bit          halt_ok = 1'b0;
   int          items_made = 0;
   int          n_errors = 0;
   int          n_req = 0;
   int          n_ticks = 0;
   int          n_outs = 0;
   bit          req_took = 1'b0;
   int          gap_left = 0;
   int          burst_left = 1;
   int          rx_left = 0;
   int          rx_mode = 0;
   int          stall_left = 0;

   always #6 clock = ~clock;

   microcoded_8bit_cpu_step dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic logic [9:0] store_addr(input int s);
      return {regs[s].zero, regs[s].carry, 1'b0, regs[s].ir[7:4], regs[s].step};
   endfunction

   // advances state copy s by one request and returns the response it owes
   function automatic mcpu_pkg::rsp_type cpu_step(input int s, input mcpu_pkg::act_type act,
                                                  input logic [9:0] laddr,
                                                  input logic [15:0] ldata);
      cpu_regs_type      st;
      mcpu_pkg::cw_type  cw;
      logic [7:0]        bus;
      logic [7:0]        bv;
      logic [8:0]        sum;
      mcpu_pkg::rsp_type r;
      st = regs[s];
      r = '0;
      if (act == mcpu_pkg::ACT_CS_WR) begin
         cstore_img[s][laddr] = ldata;
      end else if (act == mcpu_pkg::ACT_MEM_WR) begin
         ram_img[s][laddr % RAM_WORDS] = ldata[7:0];
      end else if (act == mcpu_pkg::ACT_TICK && !st.halt) begin
         cw = mcpu_pkg::cw_type'(cstore_img[s][store_addr(s)]);
         bus = '0;
         if (cw.ce) st.pc = st.pc + 8'd1;
         if (cw.hlt) st.halt = 1'b1;
         if (cw.co) begin
            bus = st.pc;
         end else if (cw.eo) begin
            bv = cw.su ? 8'd0 - st.breg : st.breg;
            sum = {1'b0, st.acc} + {1'b0, bv};
            bus = sum[7:0];
            if (cw.fi) begin
               st.zero = (bus == 8'd0);
               st.carry = sum[8];
            end
         end else if (cw.ao) begin
            bus = st.acc;
         end else if (cw.io) begin
            bus = {4'd0, st.ir[3:0]};
         end else if (cw.ro) begin
            bus = ram_img[s][st.mar % RAM_WORDS];
         end
         if (cw.j) st.pc = bus;
         if (cw.oi) begin
            r.out_valid = 1'b1;
            r.out_value = bus;
         end
         if (cw.bi) st.breg = bus;
         if (cw.ai) st.acc = bus;
         if (cw.ii) st.ir = bus;
         // ram write goes through the mar value from before this step
         if (cw.ri) ram_img[s][st.mar % RAM_WORDS] = bus;
         if (cw.mi) st.mar = bus;
         st.step = (st.step == mcpu_pkg::STEP_LAST) ? 3'd0 : st.step + 3'd1;
      end
      regs[s] = st;
      r.halted = st.halt;
      r.pc_now = st.pc;
      return r;
   endfunction

   // classic fetch / execute microcode with carry and zero conditional jumps
   function automatic logic [15:0] sap_word(input logic [9:0] ca);
      logic [2:0]  st;
      logic [15:0] w;
      st = ca[2:0];
      w = '0;
      if (st == 3'd0) begin
         w = CW_CO | CW_MI;
      end else if (st == 3'd1) begin
         w = CW_RO | CW_II | CW_CE;
      end else begin
         case (ca[6:3])
            OP_LDA: w = (st == 3'd2) ? CW_IO | CW_MI : (st == 3'd3) ? CW_RO | CW_AI : '0;
            OP_ADD, OP_SUB: begin
               if (st == 3'd2) w = CW_IO | CW_MI;
               else if (st == 3'd3) w = CW_RO | CW_BI;
               else w = CW_EO | CW_AI | CW_FI | ((ca[6:3] == OP_SUB) ? CW_SU : '0);
            end
            OP_STA: w = (st == 3'd2) ? CW_IO | CW_MI : (st == 3'd3) ? CW_AO | CW_RI : '0;
            OP_LDI: w = (st == 3'd2) ? CW_IO | CW_AI : '0;
            OP_JMP: w = (st == 3'd2) ? CW_IO | CW_J : '0;
            OP_JC: w = (st == 3'd2 && ca[8]) ? CW_IO | CW_J : '0;
            OP_JZ: w = (st == 3'd2 && ca[9]) ? CW_IO | CW_J : '0;
            OP_ADI: w = (st == 3'd2) ? CW_IO | CW_BI : (st == 3'd3) ? CW_EO | CW_AI | CW_FI : '0;
            OP_OUT: w = (st == 3'd2) ? CW_AO | CW_OI : '0;
            OP_HLT: w = (st != 3'd2) ? '0 : halt_ok ? CW_HLT : CW_AO | CW_OI;
            default: w = '0;
         endcase
      end
      return w;
   endfunction

   task automatic push_item(input mcpu_pkg::act_type act, input logic [9:0] la,
                            input logic [15:0] ld);
      if (act != mcpu_pkg::ACT_NOP && !(act == mcpu_pkg::ACT_TICK && regs[GEN].halt))
         items_made++;
      if (act == mcpu_pkg::ACT_CS_WR) cs_written[la] = 1'b1;
      pend_q.push_back({hold_next, act, la, ld});
      hold_next = 1'b0;
      void'(cpu_step(GEN, act, la, ld));
   endtask

   // makes sure the word this tick will fetch is loaded, then ticks
   task automatic issue_tick(input logic [15:0] word, input bit replace);
      logic [9:0] ca;
      ca = store_addr(GEN);
      if (!cs_written[ca] || (replace && cstore_img[GEN][ca] != word))
         push_item(mcpu_pkg::ACT_CS_WR, ca, word);
      push_item(mcpu_pkg::ACT_TICK, 10'($urandom), 16'($urandom));
   endtask

   task automatic check_field(input string what, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (got_v !== want_v) begin
         n_errors++;
         $display("%0t tb: %s mismatch, expected %h actual %h", $time, what, want_v, got_v);
      end
   endtask

   // stimulus, reset and end of run
   initial begin : stim_proc
      int         base;
      int         r;
      int         phase;
      logic [3:0] op;
      regs[GEN] = '0;
      regs[CHK] = '0;

      push_item(mcpu_pkg::ACT_NOP, 10'h3FF, 16'hFFFF);
      for (int i = 0; i < RAM_WORDS; i++) begin
         push_item(mcpu_pkg::ACT_MEM_WR,
                   (i == RAM_WORDS - 1) ? 10'h3FF :
                   (i == 0) ? 10'h000 : 10'(i + RAM_WORDS * $urandom_range(0, 63)),
                   (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom));
      end
      // step field seven is never formed, so this entry is never fetched
      push_item(mcpu_pkg::ACT_CS_WR, 10'h3FF, 16'hFFFF);
      issue_tick(CW_CO | CW_MI | CW_CE | CW_OI, 1'b1);
      issue_tick(CW_RO | CW_II | CW_AI | CW_OI, 1'b1);
      issue_tick(CW_EO | CW_SU | CW_FI | CW_BI | CW_OI, 1'b1);
      issue_tick(CW_EO | CW_FI | CW_AO | CW_J | CW_OI, 1'b1);
      issue_tick(CW_IO | CW_RO | CW_RI | CW_MI | CW_OI, 1'b1);
      issue_tick(CW_AO | CW_RO | CW_OI, 1'b1);

      phase = 0;
      while (items_made < TARGET_ITEMS) begin
         hold_next = 1'b1;
         base = items_made;
         if (phase % 2 == 0) begin
            // fresh program in memory, then run it under sap microcode
            for (int i = 0; i < RAM_WORDS; i++) begin
               case ($urandom_range(0, 11))
                  0: op = OP_LDA;
                  1: op = OP_ADD;
                  2: op = OP_SUB;
                  3: op = OP_STA;
                  4: op = OP_LDI;
                  5: op = OP_JMP;
                  6: op = OP_JC;
                  7: op = OP_JZ;
                  8: op = OP_ADI;
                  9: op = OP_OUT;
                  10: op = OP_NOP;
                  default: op = 4'($urandom);
               endcase
               push_item(mcpu_pkg::ACT_MEM_WR, 10'($urandom_range(0, 63) * RAM_WORDS + i),
                         {8'($urandom), op, 4'($urandom)});
            end
            while (items_made - base < 150) begin
               r = $urandom_range(0, 99);
               if (r < 4)
                  push_item(mcpu_pkg::ACT_MEM_WR, 10'($urandom), 16'($urandom));
               else if (r < 8)
                  push_item(mcpu_pkg::ACT_NOP, 10'($urandom), 16'($urandom));
               else if (r < 10)
                  push_item(mcpu_pkg::ACT_CS_WR, 10'($urandom), 16'($urandom) & ~CW_HLT);
               else
                  issue_tick(sap_word(store_addr(GEN)), 1'b1);
            end
         end else begin
            // random control words, store rewritten under the running machine
            while (items_made - base < 100) begin
               r = $urandom_range(0, 99);
               if (r < 5)
                  push_item(mcpu_pkg::ACT_MEM_WR, 10'($urandom), 16'($urandom));
               else if (r < 8)
                  push_item(mcpu_pkg::ACT_NOP, 10'($urandom), 16'($urandom));
               else if (r < 15)
                  push_item(mcpu_pkg::ACT_CS_WR, 10'($urandom), 16'($urandom) & ~CW_HLT);
               else
                  issue_tick(16'($urandom) & ~CW_HLT, $urandom_range(0, 2) == 0);
            end
         end
         phase++;
      end

      // halt once, then show ticks and loads after halt
      hold_next = 1'b1;
      halt_ok = 1'b1;
      issue_tick(CW_HLT | CW_AO | CW_OI | CW_CE, 1'b1);
      repeat (3) issue_tick(16'($urandom), 1'b0);
      push_item(mcpu_pkg::ACT_CS_WR, 10'($urandom), 16'($urandom));
      push_item(mcpu_pkg::ACT_MEM_WR, 10'($urandom), 16'($urandom));
      push_item(mcpu_pkg::ACT_NOP, 10'($urandom), 16'($urandom));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pend_q.size() != 0 || req_tvalid || want_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("tb: %0d requests checked, %0d ticks, %0d output latches", n_req, n_ticks, n_outs);
      $display("tb: sap programs, random microcode, live store rewrites and post-halt ticks");
      if (n_errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin : limit_proc
      #5_000_000;
      $display("tb: run timed out");
      $display("tb: FAIL");
      $finish;
   end

   // sender bursts and receiver stall pattern, driven on the falling edge
   always @(negedge clock) begin : drive_proc
      logic         nv;
      logic         nr;
      req_item_type cur;
      if (!reset) begin
         nv = req_tvalid && !req_took;   // an offered request stays until taken
         if (!nv) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pend_q.size() != 0 && !(pend_q[0].hold && want_rsp_q.size() != 0)) begin
               cur = pend_q.pop_front();
               req_tdata <= {6'd0, cur.ldata, cur.laddr};
               req_tuser <= cur.act;
               nv = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         req_tvalid <= nv;

         if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
         end
         rx_left--;
         case (rx_mode)
            0: nr = 1'b1;
            1: nr = 1'($urandom_range(0, 1));
            2: nr = ($urandom_range(0, 3) == 0);
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  nr = 1'b0;
               end else begin
                  nr = 1'b1;
                  if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 15);
               end
            end
         endcase
         rsp_tready <= nr;
      end
   end

   // request prediction and response checking on the rising edge
   always @(posedge clock) begin : watch_proc
      mcpu_pkg::rsp_type want;
      req_took = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_took = 1'b1;
            want = cpu_step(CHK, mcpu_pkg::act_type'(req_tuser), req_tdata[9:0],
                            req_tdata[25:10]);
            want_rsp_q.push_back(want);
            n_req++;
            if (mcpu_pkg::act_type'(req_tuser) == mcpu_pkg::ACT_TICK) n_ticks++;
            if (want.out_valid) n_outs++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (want_rsp_q.size() == 0) begin
               n_errors++;
               $display("%0t tb: response with none pending, expected none actual %h/%h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = want_rsp_q.pop_front();
               check_field("out_valid", {7'd0, want.out_valid}, {7'd0, rsp_tuser[0]});
               check_field("out_value", want.out_value, rsp_tdata[7:0]);
               check_field("halted", {7'd0, want.halted}, {7'd0, rsp_tdata[8]});
               check_field("pc_now", want.pc_now, rsp_tdata[16:9]);
            end
         end
      end
   end

endmodule

/* files.f */
sv/mcpu_pkg.sv
sv/mcpu_cstore.sv
sv/mcpu_ram.sv
sv/mcpu_core.sv
sv/microcoded_8bit_cpu_step.sv
tb/tb.sv
